// ===== hw/rtl/qat_pkg.sv =====
// qat_pkg: shared types and constants of the quoted argument tokenizer
// result kinds, the result group passed from front to back, queue depth default
`default_nettype none

package qat_pkg;

    localparam int QAT_SLOTS      = 3;
    localparam int QAT_FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic [QAT_SLOTS-1:0][7:0] data;
        logic [QAT_SLOTS-1:0][1:0] kind;
        logic [1:0]                cnt;
    } group_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qat_front.sv =====
// qat_front: accepts input bytes and runs the parse state machine
// produces at most one result group per byte into the queue; depends on qat_pkg
`default_nettype none

module qat_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          fifo_full,
    output logic               push,
    output qat_pkg::group_t    push_grp
);
    import qat_pkg::*;

    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_UNQ     = 4'd1;
    localparam logic [3:0] MODE_DQ      = 4'd2;
    localparam logic [3:0] MODE_DQ_ESC  = 4'd3;
    localparam logic [3:0] MODE_DQ_HEX1 = 4'd4;
    localparam logic [3:0] MODE_DQ_HEX2 = 4'd5;
    localparam logic [3:0] MODE_SQ      = 4'd6;
    localparam logic [3:0] MODE_SQ_ESC  = 4'd7;
    localparam logic [3:0] MODE_CLOSED  = 4'd8;
    localparam logic [3:0] MODE_DISCARD = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_A     = 8'h61;

    logic [3:0] mode_reg, mode_next;
    logic [7:0] hex_reg, hex_next;
    logic       accept;
    group_t     grp;

    function automatic group_t append(group_t g, logic [1:0] k, logic [7:0] d);
        group_t r;
        r = g;
        case (g.cnt)
            2'd0: begin
                r.kind[0] = k;
                r.data[0] = (k == KIND_BYTE) ? d : 8'd0;
                r.cnt     = 2'd1;
            end
            2'd1: begin
                r.kind[1] = k;
                r.data[1] = (k == KIND_BYTE) ? d : 8'd0;
                r.cnt     = 2'd2;
            end
            2'd2: begin
                r.kind[2] = k;
                r.data[2] = (k == KIND_BYTE) ? d : 8'd0;
                r.cnt     = 2'd3;
            end
            default: r = g;
        endcase
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b inside {CH_SPACE, [8'd9:8'd13]};
    endfunction

    // unquoted text ends at space, tab, cr, lf or end of line
    function automatic logic b_is_end(logic [7:0] b);
        return b inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            v = b[3:0];
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

    // plain handling inside double or single quotes
    function automatic group_t quoted_grp(group_t g, logic [7:0] b, logic [7:0] close_ch);
        group_t r;
        r = g;
        if (b == CH_NUL) begin
            r = append(g, KIND_ERROR, 8'd0);
        end else if (b != CH_BSL && b != close_ch) begin
            r = append(g, KIND_BYTE, b);
        end
        return r;
    endfunction

    function automatic logic [3:0] quoted_mode(logic [7:0] b, logic [7:0] close_ch,
                                               logic [3:0] stay, logic [3:0] esc);
        logic [3:0] m;
        m = stay;
        if (b == CH_BSL) begin
            m = esc;
        end else if (b == close_ch) begin
            m = MODE_CLOSED;
        end else if (b == CH_NUL) begin
            m = MODE_IDLE;
        end
        return m;
    endfunction

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        grp       = '0;
        mode_next = mode_reg;
        hex_next  = hex_reg;
        case (mode_reg)
            MODE_IDLE, MODE_UNQ: begin
                if (mode_reg == MODE_UNQ && b_is_end(s_tdata)) begin
                    grp = append(grp, KIND_TOKEN, 8'd0);
                    if (s_tdata == CH_NUL) begin
                        grp = append(grp, KIND_LINE, 8'd0);
                    end
                    mode_next = MODE_IDLE;
                end else if (mode_reg == MODE_IDLE && s_tdata == CH_NUL) begin
                    grp = append(grp, KIND_LINE, 8'd0);
                end else if (mode_reg == MODE_IDLE && is_blank(s_tdata)) begin
                    mode_next = MODE_IDLE;
                end else if (s_tdata == CH_DQ) begin
                    mode_next = MODE_DQ;
                end else if (s_tdata == CH_SQ) begin
                    mode_next = MODE_SQ;
                end else begin
                    grp       = append(grp, KIND_BYTE, s_tdata);
                    mode_next = MODE_UNQ;
                end
            end
            MODE_DQ: begin
                grp       = quoted_grp(grp, s_tdata, CH_DQ);
                mode_next = quoted_mode(s_tdata, CH_DQ, MODE_DQ, MODE_DQ_ESC);
            end
            MODE_DQ_ESC: begin
                mode_next = MODE_DQ;
                case (s_tdata)
                    CH_X: mode_next = MODE_DQ_HEX1;
                    CH_N: grp = append(grp, KIND_BYTE, CH_LF);
                    CH_R: grp = append(grp, KIND_BYTE, CH_CR);
                    CH_T: grp = append(grp, KIND_BYTE, CH_TAB);
                    CH_B: grp = append(grp, KIND_BYTE, CH_BS);
                    CH_A: grp = append(grp, KIND_BYTE, CH_BEL);
                    CH_NUL: begin
                        grp       = append(grp, KIND_BYTE, CH_BSL);
                        grp       = append(grp, KIND_ERROR, 8'd0);
                        mode_next = MODE_IDLE;
                    end
                    default: grp = append(grp, KIND_BYTE, s_tdata);
                endcase
            end
            MODE_DQ_HEX1: begin
                if (is_hex(s_tdata)) begin
                    hex_next  = s_tdata;
                    mode_next = MODE_DQ_HEX2;
                end else begin
                    grp       = append(grp, KIND_BYTE, CH_X);
                    grp       = quoted_grp(grp, s_tdata, CH_DQ);
                    mode_next = quoted_mode(s_tdata, CH_DQ, MODE_DQ, MODE_DQ_ESC);
                end
            end
            MODE_DQ_HEX2: begin
                if (is_hex(s_tdata)) begin
                    grp       = append(grp, KIND_BYTE, {hex_val(hex_reg), hex_val(s_tdata)});
                    mode_next = MODE_DQ;
                end else begin
                    grp       = append(grp, KIND_BYTE, CH_X);
                    grp       = append(grp, KIND_BYTE, hex_reg);
                    grp       = quoted_grp(grp, s_tdata, CH_DQ);
                    mode_next = quoted_mode(s_tdata, CH_DQ, MODE_DQ, MODE_DQ_ESC);
                end
            end
            MODE_SQ: begin
                grp       = quoted_grp(grp, s_tdata, CH_SQ);
                mode_next = quoted_mode(s_tdata, CH_SQ, MODE_SQ, MODE_SQ_ESC);
            end
            MODE_SQ_ESC: begin
                if (s_tdata == CH_SQ) begin
                    grp       = append(grp, KIND_BYTE, CH_SQ);
                    mode_next = MODE_SQ;
                end else begin
                    grp       = append(grp, KIND_BYTE, CH_BSL);
                    grp       = quoted_grp(grp, s_tdata, CH_SQ);
                    mode_next = quoted_mode(s_tdata, CH_SQ, MODE_SQ, MODE_SQ_ESC);
                end
            end
            MODE_CLOSED: begin
                if (s_tdata == CH_NUL) begin
                    grp       = append(grp, KIND_TOKEN, 8'd0);
                    grp       = append(grp, KIND_LINE, 8'd0);
                    mode_next = MODE_IDLE;
                end else if (is_blank(s_tdata)) begin
                    grp       = append(grp, KIND_TOKEN, 8'd0);
                    mode_next = MODE_IDLE;
                end else begin
                    grp       = append(grp, KIND_ERROR, 8'd0);
                    mode_next = MODE_DISCARD;
                end
            end
            MODE_DISCARD: begin
                if (s_tdata == CH_NUL) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    assign push     = accept && (grp.cnt != 2'd0);
    assign push_grp = grp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            hex_reg  <= 8'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qat_fifo.sv =====
// qat_fifo: short register queue of result groups between front and back
// depends on qat_pkg for the group type
`default_nettype none

module qat_fifo #(
    parameter int DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire qat_pkg::group_t  push_grp,
    input  wire logic             pop,
    output qat_pkg::group_t       pop_grp,
    output logic                  full,
    output logic                  empty
);
    import qat_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    group_t          entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_grp = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qat_back.sv =====
// qat_back: sends queued result groups one item a cycle while m_tready is high
// marks the final item of each group with tlast; depends on qat_pkg
`default_nettype none

module qat_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire qat_pkg::group_t  fifo_grp,
    input  wire logic             fifo_empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [1:0]            out_kind,
    output logic [7:0]            out_byte,
    output logic                  m_tlast
);
    import qat_pkg::*;

    group_t     grp_reg, grp_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       take, load, at_last;

    assign at_last = (idx_reg == grp_reg.cnt - 2'd1);
    assign take    = valid_reg && m_tready;
    assign load    = !valid_reg || (take && at_last);
    assign pop     = load && !fifo_empty;

    always_comb begin
        grp_next   = grp_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = !fifo_empty;
            grp_next   = fifo_grp;
            idx_next   = 2'd0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0: begin
                out_kind = grp_reg.kind[0];
                out_byte = grp_reg.data[0];
            end
            2'd1: begin
                out_kind = grp_reg.kind[1];
                out_byte = grp_reg.data[1];
            end
            2'd2: begin
                out_kind = grp_reg.kind[2];
                out_byte = grp_reg.data[2];
            end
            default: begin
                out_kind = KIND_BYTE;
                out_byte = 8'd0;
            end
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/quoted_argument_tokenizer.sv =====
// quoted_argument_tokenizer: top level, front parser, group queue and output sender
// depends on qat_pkg, qat_front, qat_fifo, qat_back
//
//   channel  direction  tdata             tuser           tlast
//   s_       in         [7:0] in_byte     -               -
//   m_       out        [7:0] out_byte    [1:0] out_kind  final item of a byte
//
// one input byte a cycle while the queue has room; each byte leaves 0 to 3 items
// the output side sends one item a cycle while m_tready is high
// a queue of FIFO_DEPTH result groups lets the input run on while the output stalls
// reset puts the parser between tokens and empties the queue and the output
`default_nettype none

module quoted_argument_tokenizer #(
    parameter int FIFO_DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast
);
    import qat_pkg::*;

    group_t     push_grp, pop_grp;
    logic       push, pop, fifo_full, fifo_empty;
    logic [1:0] out_kind;
    logic [7:0] out_byte;

    qat_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push),
        .push_grp  (push_grp)
    );

    qat_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .pop_grp  (pop_grp),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    qat_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_grp   (pop_grp),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = out_byte;
    assign m_tuser = out_kind;

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_grp.cnt != 2'd0))
        else $error("empty result group pushed");

    a_marks_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_kind == KIND_BYTE || out_byte == 8'd0))
        else $error("non-byte item carries data");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_kind == KIND_ERROR || out_kind == KIND_LINE)) |-> m_tlast)
        else $error("line end or error not final item");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== tb/tokenizer_checker.sv =====
// tokenizer_checker: watches both channels of the quoted argument tokenizer,
// predicts the items each accepted input byte causes and compares them in order
// depends on qat_pkg for the result kinds and the slot count
`default_nettype none

module tokenizer_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] out_byte
    input  wire logic [1:0]  m_tuser,   // [1:0] out_kind
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               items_due
);
    import qat_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BARE, ST_DQ, ST_DQ_ESC, ST_HEX_FIRST, ST_HEX_SECOND,
        ST_SQ, ST_SQ_ESC, ST_CLOSED, ST_DISCARD
    } scan_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } arg_item_t;

    scan_t      scan_mode;
    logic [7:0] first_hex;
    arg_item_t  step_out[QAT_SLOTS];
    int         step_n;
    arg_item_t  args_due[$];
    int         fails;

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value);
        if (step_n < QAT_SLOTS) begin
            step_out[step_n].kind = kind;
            step_out[step_n].data = (kind == KIND_BYTE) ? value : 8'h00;
            step_out[step_n].last = 1'b0;
            step_n++;
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= "9")
            return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    function automatic void open_or_bare(input logic [7:0] b);
        if (b == "\"") begin
            scan_mode = ST_DQ;
        end else if (b == "'") begin
            scan_mode = ST_SQ;
        end else begin
            emit(KIND_BYTE, b);
            scan_mode = ST_BARE;
        end
    endfunction

    function automatic void dq_text(input logic [7:0] b);
        if (b == "\\") begin
            scan_mode = ST_DQ_ESC;
        end else if (b == "\"") begin
            scan_mode = ST_CLOSED;
        end else if (b == 8'h00) begin
            emit(KIND_ERROR, 8'h00);
            scan_mode = ST_IDLE;
        end else begin
            emit(KIND_BYTE, b);
        end
    endfunction

    function automatic void sq_text(input logic [7:0] b);
        if (b == "\\") begin
            scan_mode = ST_SQ_ESC;
        end else if (b == "'") begin
            scan_mode = ST_CLOSED;
        end else if (b == 8'h00) begin
            emit(KIND_ERROR, 8'h00);
            scan_mode = ST_IDLE;
        end else begin
            emit(KIND_BYTE, b);
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        case (scan_mode)
            ST_IDLE: begin
                if (b == 8'h00)
                    emit(KIND_LINE, 8'h00);
                else if (!is_blank(b))
                    open_or_bare(b);
            end
            ST_BARE: begin
                if (b == 8'h00) begin
                    emit(KIND_TOKEN, 8'h00);
                    emit(KIND_LINE, 8'h00);
                    scan_mode = ST_IDLE;
                end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
                    emit(KIND_TOKEN, 8'h00);
                    scan_mode = ST_IDLE;
                end else begin
                    open_or_bare(b);
                end
            end
            ST_DQ: dq_text(b);
            ST_DQ_ESC: begin
                scan_mode = ST_DQ;
                case (b)
                    "x": scan_mode = ST_HEX_FIRST;
                    "n": emit(KIND_BYTE, 8'h0A);
                    "r": emit(KIND_BYTE, 8'h0D);
                    "t": emit(KIND_BYTE, 8'h09);
                    "b": emit(KIND_BYTE, 8'h08);
                    "a": emit(KIND_BYTE, 8'h07);
                    8'h00: begin
                        emit(KIND_BYTE, "\\");
                        dq_text(b);
                    end
                    default: emit(KIND_BYTE, b);
                endcase
            end
            ST_HEX_FIRST: begin
                if (is_hex(b)) begin
                    first_hex = b;
                    scan_mode = ST_HEX_SECOND;
                end else begin
                    emit(KIND_BYTE, "x");
                    scan_mode = ST_DQ;
                    dq_text(b);
                end
            end
            ST_HEX_SECOND: begin
                scan_mode = ST_DQ;
                if (is_hex(b)) begin
                    emit(KIND_BYTE, {hex_nibble(first_hex), hex_nibble(b)});
                end else begin
                    emit(KIND_BYTE, "x");
                    emit(KIND_BYTE, first_hex);
                    dq_text(b);
                end
            end
            ST_SQ: sq_text(b);
            ST_SQ_ESC: begin
                scan_mode = ST_SQ;
                if (b == "'") begin
                    emit(KIND_BYTE, "'");
                end else begin
                    emit(KIND_BYTE, "\\");
                    sq_text(b);
                end
            end
            ST_CLOSED: begin
                if (b == 8'h00) begin
                    emit(KIND_TOKEN, 8'h00);
                    emit(KIND_LINE, 8'h00);
                    scan_mode = ST_IDLE;
                end else if (is_blank(b)) begin
                    emit(KIND_TOKEN, 8'h00);
                    scan_mode = ST_IDLE;
                end else begin
                    emit(KIND_ERROR, 8'h00);
                    scan_mode = ST_DISCARD;
                end
            end
            ST_DISCARD: begin
                if (b == 8'h00)
                    scan_mode = ST_IDLE;
            end
            default: scan_mode = ST_IDLE;
        endcase
    endfunction

    always @(posedge aclk) begin
        arg_item_t  want;
        logic [1:0] got_kind;
        logic [7:0] got_byte;
        if (!aresetn) begin
            scan_mode = ST_IDLE;
            first_hex = 8'h00;
            args_due.delete();
            fails = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_kind = m_tuser;
                got_byte = m_tdata;
                if (args_due.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected item: kind %0d byte %02h last %0b",
                                 got_kind, got_byte, m_tlast);
                    fails++;
                end else begin
                    want = args_due.pop_front();
                    if (want.kind != got_kind || want.data != got_byte ||
                        want.last != m_tlast) begin
                        if (fails < 10)
                            $display({"item mismatch: expected kind %0d byte %02h last %0b,",
                                      " got kind %0d byte %02h last %0b"},
                                     want.kind, want.data, want.last,
                                     got_kind, got_byte, m_tlast);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                step_n = 0;
                tokenize_byte(s_tdata);
                for (int i = 0; i < step_n; i++) begin
                    step_out[i].last = (i == step_n - 1);
                    args_due.push_back(step_out[i]);
                end
            end
        end
        fail_count <= fails;
        items_due  <= args_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: drives command lines into the quoted argument tokenizer and gives the verdict
// depends on quoted_argument_tokenizer and tokenizer_checker
`default_nettype none

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int args_pending;
    int cycle_count = 0;
    int stall_left = 0;
    int recv_calm = 0;
    int send_calm = 0;

    logic [7:0] line_bytes[$];
    logic [7:0] blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [7:0] token_seps[4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

    quoted_argument_tokenizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tokenizer_checker tok_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (mismatch_count),
        .items_due  (args_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall before each item, with calm stretches
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (recv_calm > 0) begin
                hold = 0;
                recv_calm <= recv_calm - 1;
            end else begin
                hold = $urandom_range(0, 19);
                if ($urandom_range(0, 15) == 0)
                    recv_calm <= $urandom_range(5, 30);
            end
            m_tready <= (hold == 0);
            stall_left <= hold;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_excluding(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == a || v == b);
        return v;
    endfunction

    function automatic logic [7:0] rand_bare();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == "\"" || v == "'" || v == 8'h20 || v == 8'h09 || v == 8'h0D || v == 8'h0A);
        return v;
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_non_hex_letter();
        return 8'("g") + 8'($urandom_range(0, 19));
    endfunction

    function automatic void put_bare_text();
        repeat ($urandom_range(1, 4))
            line_bytes.push_back(rand_bare());
    endfunction

    function automatic void put_dq_body();
        string named = "nrtba";
        line_bytes.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 6))
                0, 1: line_bytes.push_back(rand_excluding("\"", "\\"));
                2: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back(named[$urandom_range(0, 4)]);
                end
                3: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back("x");
                    line_bytes.push_back(rand_hex_digit());
                    line_bytes.push_back(rand_hex_digit());
                end
                4: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back("x");
                    line_bytes.push_back(rand_non_hex_letter());
                end
                5: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back("x");
                    line_bytes.push_back(rand_hex_digit());
                    line_bytes.push_back(rand_non_hex_letter());
                end
                default: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back(rand_excluding("x", "x"));
                end
            endcase
        end
    endfunction

    function automatic void put_sq_body();
        line_bytes.push_back("'");
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
                0, 1: line_bytes.push_back(rand_excluding("'", "\\"));
                2: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back("'");
                end
                default: begin
                    line_bytes.push_back("\\");
                    line_bytes.push_back(rand_excluding("'", "\\"));
                end
            endcase
        end
    endfunction

    function automatic void put_quoted();
        if ($urandom_range(0, 1) == 0) begin
            put_dq_body();
            line_bytes.push_back("\"");
        end else begin
            put_sq_body();
            line_bytes.push_back("'");
        end
    endfunction

    function automatic void put_clean_line();
        int shape;
        repeat ($urandom_range(0, 2))
            line_bytes.push_back(blank_set[$urandom_range(0, 5)]);
        repeat ($urandom_range(0, 4)) begin
            shape = $urandom_range(0, 5);
            if (shape != 1 && shape != 2)
                put_bare_text();
            if (shape >= 1 && shape <= 4)
                put_quoted();
            line_bytes.push_back(token_seps[$urandom_range(0, 3)]);
        end
        line_bytes.push_back(8'h00);
    endfunction

    function automatic void put_broken_line();
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(1, 8))
                    line_bytes.push_back(8'($urandom_range(1, 255)));
            end
            1: begin
                // closing quote followed by text, then junk up to line end
                put_quoted();
                line_bytes.push_back(rand_bare());
                repeat ($urandom_range(0, 4))
                    line_bytes.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
                if ($urandom_range(0, 1) == 0)
                    put_dq_body();
                else
                    put_sq_body();
                case ($urandom_range(0, 3))
                    0: line_bytes.push_back("\\");
                    1: begin
                        line_bytes.push_back("\\");
                        line_bytes.push_back("x");
                    end
                    default: ;
                endcase
            end
        endcase
        line_bytes.push_back(8'h00);
    endfunction

    function automatic void build_stimulus();
        int target;
        line_bytes = '{8'h00,
                       8'h20, 8'h0D, 8'h00,
                       8'h09, 8'hFF, 8'h0B, "\"", "\\", "n", "\\", "x", "A", "f", "\"", 8'h0C,
                       "'", "\\", "'", "'", 8'h00,
                       "\"", "\"", "x", "z", 8'h00,
                       "\"", "\\", "x", 8'h00};
        target = line_bytes.size() + RANDOM_BYTES;
        while (line_bytes.size() < target) begin
            if ($urandom_range(0, 4) == 0)
                put_broken_line();
            else
                put_clean_line();
        end
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0)
                send_calm = $urandom_range(5, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        build_stimulus();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (args_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && args_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/qat_pkg.sv
hw/rtl/qat_front.sv
hw/rtl/qat_fifo.sv
hw/rtl/qat_back.sv
hw/rtl/quoted_argument_tokenizer.sv
tb/tokenizer_checker.sv
tb/testbench.sv
